### rtl/assert_macros.svh
// Assertion macros for the RTL files; the detector module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/lwcd_pkg.sv
// Package: constants, event codes and transaction types for the lock wait cycle detector.
package lwcd_pkg;

  localparam int THREAD_SLOTS = 16;
  localparam int LOCK_SLOTS   = 64;

  localparam int TID_W  = $clog2(THREAD_SLOTS);
  localparam int LID_W  = $clog2(LOCK_SLOTS);
  localparam int KIND_W = 2;
  localparam int CNT_W  = 5;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_INTEND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  thread_id;
    logic [LID_W-1:0]  lock_id;
  } in_item_t;

  typedef struct packed {
    logic              deadlock;
    logic [CNT_W-1:0]  cycle_threads;
    logic [TID_W-1:0]  closing_thread;
  } out_item_t;

endpackage

### rtl/lock_wait_cycle_detector.sv
// Lock wait cycle detector: owner/wait tables and the wait-for chain walker.
// Each lock event returns exactly one result transaction. Acquire, release,
// unused kinds and all events while disabled go from acceptance to S_DONE,
// where the result waits until the output register is free. An intend event
// walks the wait-for chain in S_CHECK at one hop per cycle, bounded by the
// single-port owner table read that each hop needs, for H hops, H from 1 to
// THREAD_SLOTS. The next event is accepted from the cycle after the result
// is loaded. Input ready is high only while the walker is idle; a finished
// result waits in the output register, and the next event may be accepted
// meanwhile. The user must write the enable register through cfg_wen/cfg_wdata
// only while idle; the block itself does not enforce this.
`include "assert_macros.svh"

module lock_wait_cycle_detector (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  lwcd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lwcd_pkg::out_item_t out_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  logic [1:0] state;
  logic       enable;

  // Owner table: thread ids in memory, valid bits in flops
  logic [lwcd_pkg::TID_W-1:0] own_mem [lwcd_pkg::LOCK_SLOTS];
  logic [lwcd_pkg::LOCK_SLOTS-1:0] own_valid;
  logic [lwcd_pkg::TID_W-1:0] own_q;
  logic                       own_vq;

  // Waiting table
  logic [lwcd_pkg::THREAD_SLOTS-1:0] wait_valid;
  logic [lwcd_pkg::LID_W-1:0]        wait_lock [lwcd_pkg::THREAD_SLOTS];

  // Walk state
  logic [lwcd_pkg::THREAD_SLOTS-1:0] marks;
  logic [lwcd_pkg::CNT_W-1:0]        len;
  lwcd_pkg::out_item_t               res;

  logic                       accept;
  logic                       do_intend;
  logic                       do_acq;
  logic                       do_rel;
  logic                       in_check;
  logic                       hit_mark;
  logic                       step;
  logic                       out_load;
  logic [lwcd_pkg::LID_W-1:0] rd_addr;

  // Handshake and event decode
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign do_intend = accept && enable && (in_data.kind == lwcd_pkg::KIND_INTEND);
  assign do_acq    = accept && enable && (in_data.kind == lwcd_pkg::KIND_ACQUIRE);
  assign do_rel    = accept && enable && (in_data.kind == lwcd_pkg::KIND_RELEASE);
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  // Hop evaluation on the registered owner read
  assign in_check = (state == S_CHECK);
  assign hit_mark = own_vq && marks[own_q];
  assign step     = own_vq && !marks[own_q] && wait_valid[own_q];

  // Owner read address: first lock on accept, then the owner's waited lock
  assign rd_addr = (state == S_IDLE) ? in_data.lock_id : wait_lock[own_q];

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      enable     <= 1'b0;
      out_valid  <= 1'b0;
      own_valid  <= '0;
      wait_valid <= '0;
      marks      <= '0;
    end else begin
      if (cfg_wen) begin
        enable <= cfg_wdata;
      end
      // a new result replaces the one leaving in the same cycle
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (do_intend) begin
            wait_valid[in_data.thread_id] <= 1'b1;
            marks <= lwcd_pkg::THREAD_SLOTS'(1) << in_data.thread_id;
            state <= S_CHECK;
          end else if (accept) begin
            if (do_acq) begin
              own_valid[in_data.lock_id]    <= 1'b1;
              wait_valid[in_data.thread_id] <= 1'b0;
            end else if (do_rel) begin
              own_valid[in_data.lock_id] <= 1'b0;
            end
            state <= S_DONE;
          end
        end
        S_CHECK: begin
          if (step) begin
            marks <= marks | (lwcd_pkg::THREAD_SLOTS'(1) << own_q);
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Tables, owner read port and walk datapath
  always_ff @(posedge clk) begin
    own_q  <= own_mem[rd_addr];
    own_vq <= own_valid[rd_addr];
    if (do_acq) begin
      own_mem[in_data.lock_id] <= in_data.thread_id;
    end
    if (do_intend) begin
      wait_lock[in_data.thread_id] <= in_data.lock_id;
    end
    if (do_intend) begin
      len <= lwcd_pkg::CNT_W'(1);
    end else if (in_check && step) begin
      len <= len + lwcd_pkg::CNT_W'(1);
    end
    if (accept) begin
      res <= '0;
    end else if (in_check && hit_mark) begin
      res.deadlock       <= 1'b1;
      res.cycle_threads  <= len + lwcd_pkg::CNT_W'(1);
      res.closing_thread <= own_q;
    end
    if (out_load) begin
      out_data <= res;
    end
  end

  // No-deadlock results carry zero count and thread
  `ASSERT_IMPLY(a_quiet_result, clk, rst, out_valid && !out_data.deadlock,
    (out_data.cycle_threads == '0) && (out_data.closing_thread == '0))
  // A reported cycle always holds at least the waiter and the closer
  `ASSERT_IMPLY(a_cycle_len, clk, rst, out_valid && out_data.deadlock,
    out_data.cycle_threads >= lwcd_pkg::CNT_W'(2))
  // During a walk the path length tracks the marked threads
  `ASSERT_IMPLY(a_marks_len, clk, rst, state == S_CHECK,
    $countones(marks) == 32'(len))
  // A finished result is handed to the output register when it is free
  `ASSERT_NEXT(a_done_load, clk, rst, (state == S_DONE) && !out_valid,
    out_valid && (state == S_IDLE))

endmodule
